// ===== design/pfrl_pkg.sv =====
// ----------------------------------------------------------------------------
// pfrl_pkg
// Shared types, constants and the signature table for the packet filter.
// ----------------------------------------------------------------------------
`default_nettype none

package pfrl_pkg;

  localparam int SIG_LEN     = 12;
  localparam int TIME_WIDTH  = 32;
  localparam int POS_W       = 16;
  localparam int HB_W        = 6;
  localparam int COUNT_W     = 17;
  localparam int THRESH_W    = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  localparam logic [7:0]            PROTO_UDP     = 8'd17;
  localparam logic [THRESH_W-1:0]   RATE_RESET    = 16'd50;
  localparam logic [CFG_DATA_W-1:0] WINDOW_RESET  = 32'd1000000;
  localparam logic [COUNT_W-1:0]    COUNT_MAX     = {COUNT_W{1'b1}};
  localparam logic [POS_W-1:0]      POS_MAX       = {POS_W{1'b1}};

  localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_ENABLE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SIG_ENABLE    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PORT_ENABLE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_ENABLE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_THRESH   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_TICKS  = 3'd5;

  typedef enum logic [2:0] {
    RSN_ALLOWED    = 3'd0,
    RSN_FILTER_OFF = 3'd1,
    RSN_SIGNATURE  = 3'd2,
    RSN_PORT_ZERO  = 3'd3,
    RSN_UDP_FLOOD  = 3'd4
  } reason_t;

  typedef struct packed {
    logic [7:0]            pkt_byte;
    logic                  last_byte;
    logic [TIME_WIDTH-1:0] arrival_time;
  } pfrl_in_t;

  typedef struct packed {
    logic        pass;
    logic [2:0]  reason;
    logic [7:0]  ip_protocol;
    logic [31:0] source_addr;
  } pfrl_out_t;

  typedef struct packed {
    logic                  filter_enable;
    logic                  signature_check_enable;
    logic                  port_zero_check_enable;
    logic                  rate_limit_enable;
    logic [THRESH_W-1:0]   rate_threshold;
    logic [TIME_WIDTH-1:0] window_ticks;
  } pfrl_cfg_t;

  typedef struct packed {
    reason_t               reason;
    logic                  rate_check;
    logic [TIME_WIDTH-1:0] arrival_time;
    logic [7:0]            ip_protocol;
    logic [31:0]           source_addr;
  } pfrl_rec_t;

  function automatic logic [7:0] sig_byte(input logic [4:0] idx);
    logic [7:0] val;
    unique case (idx)
      5'd0:    val = 8'h4D;
      5'd1:    val = 8'h41;
      5'd2:    val = 8'h4C;
      5'd3:    val = 8'h57;
      5'd4:    val = 8'h41;
      5'd5:    val = 8'h52;
      5'd6:    val = 8'h45;
      5'd7:    val = 8'h5F;
      5'd8:    val = 8'h48;
      5'd9:    val = 8'h41;
      5'd10:   val = 8'h53;
      5'd11:   val = 8'h48;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== design/pfrl_front.sv =====
// ----------------------------------------------------------------------------
// pfrl_front
// Byte parser: header capture, signature match and packet classification.
// ----------------------------------------------------------------------------
`default_nettype none

module pfrl_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pfrl_pkg::pfrl_cfg_t  cfg,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pfrl_pkg::pfrl_in_t   in_data,
  input  wire logic                 q_full,
  output logic                      q_push,
  output pfrl_pkg::pfrl_rec_t       q_data
);

  localparam int RB = pfrl_pkg::SIG_LEN - 1;

  logic [pfrl_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [pfrl_pkg::HB_W-1:0]  hb_r, hb_nxt;
  logic [7:0]                 proto_r, proto_nxt;
  logic [31:0]                src_r, src_nxt;
  logic [15:0]                dport_r, dport_nxt;
  logic                       port_seen_r, port_seen_nxt;
  logic                       sig_seen_r, sig_seen_nxt;
  logic [7:0]                 recent_r [RB];
  logic [7:0]                 recent_nxt [RB];
  logic                       accept;
  logic                       hit;
  logic                       is_udp;
  logic [7:0]                 b;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && in_data.last_byte;
  assign b        = in_data.pkt_byte;

  always_comb begin
    pos_nxt       = (pos_r != pfrl_pkg::POS_MAX) ? pos_r + 1'b1 : pos_r;
    hb_nxt        = hb_r;
    proto_nxt     = proto_r;
    src_nxt       = src_r;
    dport_nxt     = dport_r;
    port_seen_nxt = port_seen_r;
    if (pos_r == '0) begin
      hb_nxt = {b[3:0], 2'b00};
    end
    if (pos_r == pfrl_pkg::POS_W'(9)) begin
      proto_nxt = b;
    end
    if (pos_r >= pfrl_pkg::POS_W'(12) && pos_r <= pfrl_pkg::POS_W'(15)) begin
      src_nxt = {src_r[23:0], b};
    end
    if (pos_r == pfrl_pkg::POS_W'(hb_r) + pfrl_pkg::POS_W'(2)) begin
      dport_nxt[15:8] = b;
    end
    if (pos_r == pfrl_pkg::POS_W'(hb_r) + pfrl_pkg::POS_W'(3)) begin
      dport_nxt[7:0] = b;
      port_seen_nxt  = 1'b1;
    end

    hit = (pos_r >= pfrl_pkg::POS_W'(RB)) && (b == pfrl_pkg::sig_byte(5'(RB)));
    for (int i = 0; i < RB; i++) begin
      if (recent_r[i] != pfrl_pkg::sig_byte(5'(i))) begin
        hit = 1'b0;
      end
    end
    sig_seen_nxt = sig_seen_r || hit;

    for (int i = 0; i < RB - 1; i++) begin
      recent_nxt[i] = recent_r[i+1];
    end
    recent_nxt[RB-1] = b;
  end

  always_comb begin
    is_udp              = (proto_nxt == pfrl_pkg::PROTO_UDP);
    q_data.rate_check   = 1'b0;
    q_data.arrival_time = in_data.arrival_time;
    q_data.ip_protocol  = proto_nxt;
    q_data.source_addr  = src_nxt;
    priority if (!cfg.filter_enable) begin
      q_data.reason = pfrl_pkg::RSN_FILTER_OFF;
    end else if (cfg.signature_check_enable && sig_seen_nxt) begin
      q_data.reason = pfrl_pkg::RSN_SIGNATURE;
    end else if (cfg.port_zero_check_enable && is_udp && port_seen_nxt &&
                 dport_nxt == '0) begin
      q_data.reason = pfrl_pkg::RSN_PORT_ZERO;
    end else begin
      q_data.reason     = pfrl_pkg::RSN_ALLOWED;
      q_data.rate_check = cfg.rate_limit_enable && is_udp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_data.last_byte)) begin
      pos_r       <= '0;
      hb_r        <= '0;
      proto_r     <= '0;
      src_r       <= '0;
      dport_r     <= '0;
      port_seen_r <= 1'b0;
      sig_seen_r  <= 1'b0;
      for (int i = 0; i < RB; i++) begin
        recent_r[i] <= '0;
      end
    end else if (accept) begin
      pos_r       <= pos_nxt;
      hb_r        <= hb_nxt;
      proto_r     <= proto_nxt;
      src_r       <= src_nxt;
      dport_r     <= dport_nxt;
      port_seen_r <= port_seen_nxt;
      sig_seen_r  <= sig_seen_nxt;
      for (int i = 0; i < RB; i++) begin
        recent_r[i] <= recent_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/pfrl_queue.sv =====
// ----------------------------------------------------------------------------
// pfrl_queue
// Small register queue of classified packet records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module pfrl_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire pfrl_pkg::pfrl_rec_t  push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      head_valid,
  output pfrl_pkg::pfrl_rec_t       head_data
);

  pfrl_pkg::pfrl_rec_t             mem_r [pfrl_pkg::QUEUE_DEPTH];
  logic [pfrl_pkg::QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [pfrl_pkg::QUEUE_CW-1:0]   count_r, count_nxt;

  assign full       = (count_r == pfrl_pkg::QUEUE_CW'(pfrl_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== design/pfrl_back.sv =====
// ----------------------------------------------------------------------------
// pfrl_back
// Verdict stage: UDP rate window, saturating counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfrl_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pfrl_pkg::pfrl_cfg_t  cfg,
  input  wire logic                 rec_valid,
  input  wire pfrl_pkg::pfrl_rec_t  rec_data,
  output logic                      rec_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pfrl_pkg::pfrl_out_t       out_data
);

  logic                              out_valid_r;
  pfrl_pkg::pfrl_out_t               out_data_r, out_data_nxt;
  logic [pfrl_pkg::COUNT_W-1:0]      count_r, count_nxt;
  logic [pfrl_pkg::TIME_WIDTH-1:0]   wstart_r, wstart_nxt;
  logic [pfrl_pkg::TIME_WIDTH-1:0]   elapsed;
  logic [pfrl_pkg::COUNT_W-1:0]      count_base;
  logic                              restart;

  assign rec_pop   = rec_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    elapsed    = rec_data.arrival_time - wstart_r;
    restart    = (elapsed >= cfg.window_ticks);
    count_base = restart ? '0 : count_r;
    count_nxt  = count_r;
    wstart_nxt = wstart_r;
    out_data_nxt.pass        = 1'b1;
    out_data_nxt.reason      = rec_data.reason;
    out_data_nxt.ip_protocol = rec_data.ip_protocol;
    out_data_nxt.source_addr = rec_data.source_addr;
    if (rec_data.reason == pfrl_pkg::RSN_SIGNATURE ||
        rec_data.reason == pfrl_pkg::RSN_PORT_ZERO) begin
      out_data_nxt.pass = 1'b0;
    end
    if (rec_data.rate_check) begin
      count_nxt  = (count_base != pfrl_pkg::COUNT_MAX) ? count_base + 1'b1 : count_base;
      wstart_nxt = restart ? rec_data.arrival_time : wstart_r;
      if (count_nxt > pfrl_pkg::COUNT_W'(cfg.rate_threshold)) begin
        out_data_nxt.pass   = 1'b0;
        out_data_nxt.reason = pfrl_pkg::RSN_UDP_FLOOD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      wstart_r    <= '0;
    end else if (rec_pop) begin
      out_valid_r <= 1'b1;
      count_r     <= count_nxt;
      wstart_r    <= wstart_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_drop_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.pass) |->
      (out_data_r.reason != pfrl_pkg::RSN_ALLOWED &&
       out_data_r.reason != pfrl_pkg::RSN_FILTER_OFF))
    else $error("drop without a drop reason");

  a_count_untouched: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_pop && !rec_data.rate_check) |=> $stable(count_r) && $stable(wstart_r))
    else $error("rate state moved for an uncounted packet");

endmodule

`default_nettype wire

// ===== design/packet_filter_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// packet_filter_rate_limiter
// IPv4 byte-stream filter with signature match, UDP port zero drop and a
// per-window UDP rate limit; one verdict per packet.
// ----------------------------------------------------------------------------
//  channel  direction  payload      handshake
//  in_      input      pfrl_in_t    in_valid / in_stall
//  out_     output     pfrl_out_t   out_valid / out_stall
//  cfg_     input      32-bit data  cfg_we, index cfg_addr
//
//  One byte is taken every cycle while in_stall is low; no other stall.
//  The last byte pushes a record; the back stage registers its verdict.
//  Verdicts wait in a four-entry queue; in_stall rises only when it is full.
//  Reset is synchronous; it restores register defaults and clears the window.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_filter_rate_limiter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire pfrl_pkg::pfrl_in_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output pfrl_pkg::pfrl_out_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [pfrl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [pfrl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  pfrl_pkg::pfrl_cfg_t cfg_r;
  pfrl_pkg::pfrl_rec_t push_data, head_data;
  logic                q_full, q_push, q_pop, head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_enable          <= 1'b1;
      cfg_r.signature_check_enable <= 1'b1;
      cfg_r.port_zero_check_enable <= 1'b1;
      cfg_r.rate_limit_enable      <= 1'b1;
      cfg_r.rate_threshold         <= pfrl_pkg::RATE_RESET;
      cfg_r.window_ticks           <= pfrl_pkg::TIME_WIDTH'(pfrl_pkg::WINDOW_RESET);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pfrl_pkg::CFG_FILTER_ENABLE: cfg_r.filter_enable          <= cfg_wdata[0];
        pfrl_pkg::CFG_SIG_ENABLE:    cfg_r.signature_check_enable <= cfg_wdata[0];
        pfrl_pkg::CFG_PORT_ENABLE:   cfg_r.port_zero_check_enable <= cfg_wdata[0];
        pfrl_pkg::CFG_RATE_ENABLE:   cfg_r.rate_limit_enable      <= cfg_wdata[0];
        pfrl_pkg::CFG_RATE_THRESH:
          cfg_r.rate_threshold <= cfg_wdata[pfrl_pkg::THRESH_W-1:0];
        pfrl_pkg::CFG_WINDOW_TICKS:
          cfg_r.window_ticks <= pfrl_pkg::TIME_WIDTH'(cfg_wdata);
        default: ;
      endcase
    end
  end

  pfrl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  pfrl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  pfrl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec_valid (head_valid),
    .rec_data  (head_data),
    .rec_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
